/* hdl/circular_queue_with_sort_defines.svh */
// Assertion macros for the circular queue.
`ifndef CIRCULAR_QUEUE_WITH_SORT_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SORT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CQS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue check failed: same-cycle rule");

// Check that cons holds in the cycle after ante.
`define CQS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue check failed: next-cycle rule");

`endif

/* hdl/cqs_pkg.sv */
package cqs_pkg;

   localparam int unsigned WORD_W = 32;

   typedef enum logic [2:0] {
      OP_ENQ       = 3'd0,
      OP_DEQ       = 3'd1,
      OP_DISP      = 3'd2,
      OP_SORT_ASC  = 3'd3,
      OP_SORT_DESC = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EMIT,
      S_DEQ,
      S_DISP,
      S_LDI,
      S_CMPJ,
      S_WB
   } state_type;

   typedef struct packed {
      logic        [2:0]        operation;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic        [1:0]        status;
      logic signed [WORD_W-1:0] element;
      logic                     element_valid;
      logic                     last;
   } rsp_type;

endpackage

/* hdl/cqs_cmp.sv */
module cqs_cmp (
   input  logic signed [cqs_pkg::WORD_W-1:0] lhs,
   input  logic signed [cqs_pkg::WORD_W-1:0] rhs,
   input  logic                              descending,
   output logic                              exchange
);

   always_comb begin
      if (descending) begin
         exchange = rhs > lhs;
      end else begin
         exchange = lhs > rhs;
      end
   end

endmodule

/* hdl/cqs_seq.sv */
module cqs_seq #(
   parameter int unsigned DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  cqs_pkg::req_type  req_data,
   output logic              req_stall,
   output logic              res_valid,
   output cqs_pkg::rsp_type  res_data,
   input  logic              out_free
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic signed [cqs_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic signed [cqs_pkg::WORD_W-1:0] rd_data_ff;

   cqs_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [PTR_W-1:0]   jptr_ff, jptr_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic signed [cqs_pkg::WORD_W-1:0] cur_ff, cur_in;
   logic [1:0]         status_ff, status_in;
   logic               desc_ff, desc_in;

   logic                              wr_en;
   logic [PTR_W-1:0]                  wr_addr;
   logic signed [cqs_pkg::WORD_W-1:0] wr_data;
   logic                              rd_en;
   logic [PTR_W-1:0]                  rd_addr;

   logic [CNT_W-1:0] cnt;
   logic             empty;
   logic             full;
   logic             exch;
   logic             disp_last;

   always_comb begin
      if (tail_ff >= head_ff) begin
         cnt = CNT_W'(tail_ff) - CNT_W'(head_ff);
      end else begin
         cnt = CNT_W'(tail_ff) + CNT_W'(DEPTH) - CNT_W'(head_ff);
      end
   end

   assign empty     = (head_ff == tail_ff);
   assign full      = (nxt(tail_ff) == head_ff);
   assign disp_last = ((i_ff + CNT_W'(1)) == cnt);

   cqs_cmp u_cmp (
      .lhs        (cur_ff),
      .rhs        (rd_data_ff),
      .descending (desc_ff),
      .exchange   (exch)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cqs_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      ptr_ff    <= ptr_in;
      jptr_ff   <= jptr_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      desc_ff   <= desc_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      ptr_in    = ptr_ff;
      jptr_in   = jptr_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      desc_in   = desc_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      wr_data   = req_data.value;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      req_stall = 1'b1;
      res_valid = 1'b0;
      res_data  = '{status: cqs_pkg::ST_DONE, element: '0, element_valid: 1'b0,
                    last: 1'b1};

      unique case (state_ff)
         cqs_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               status_in = cqs_pkg::ST_DONE;
               desc_in   = (req_data.operation == cqs_pkg::OP_SORT_DESC);
               state_in  = cqs_pkg::S_EMIT;
               unique case (req_data.operation) inside
                  cqs_pkg::OP_ENQ: begin
                     if (full) begin
                        status_in = cqs_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = nxt(tail_ff);
                     end
                  end
                  cqs_pkg::OP_DEQ: begin
                     if (empty) begin
                        status_in = cqs_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        head_in  = nxt(head_ff);
                        state_in = cqs_pkg::S_DEQ;
                     end
                  end
                  cqs_pkg::OP_DISP: begin
                     if (empty) begin
                        status_in = cqs_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        ptr_in   = head_ff;
                        i_in     = '0;
                        state_in = cqs_pkg::S_DISP;
                     end
                  end
                  cqs_pkg::OP_SORT_ASC, cqs_pkg::OP_SORT_DESC: begin
                     if (empty) begin
                        status_in = cqs_pkg::ST_EMPTY;
                     end else if (cnt > CNT_W'(1)) begin
                        rd_en    = 1'b1;
                        ptr_in   = head_ff;
                        jptr_in  = nxt(head_ff);
                        i_in     = '0;
                        j_in     = CNT_W'(1);
                        state_in = cqs_pkg::S_LDI;
                     end
                  end
                  default: begin
                     status_in = cqs_pkg::ST_DONE;
                  end
               endcase
            end
         end
         cqs_pkg::S_EMIT: begin
            res_valid       = 1'b1;
            res_data.status = status_ff;
            if (out_free) begin
               state_in = cqs_pkg::S_IDLE;
            end
         end
         cqs_pkg::S_DEQ: begin
            res_valid              = 1'b1;
            res_data.element       = rd_data_ff;
            res_data.element_valid = 1'b1;
            if (out_free) begin
               state_in = cqs_pkg::S_IDLE;
            end
         end
         cqs_pkg::S_DISP: begin
            res_valid              = 1'b1;
            res_data.element       = rd_data_ff;
            res_data.element_valid = 1'b1;
            res_data.last          = disp_last;
            if (out_free) begin
               if (disp_last) begin
                  state_in = cqs_pkg::S_IDLE;
               end else begin
                  ptr_in  = nxt(ptr_ff);
                  i_in    = i_ff + CNT_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = nxt(ptr_ff);
               end
            end
         end
         cqs_pkg::S_LDI: begin
            cur_in   = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = jptr_ff;
            state_in = cqs_pkg::S_CMPJ;
         end
         cqs_pkg::S_CMPJ: begin
            if (exch) begin
               wr_en   = 1'b1;
               wr_addr = jptr_ff;
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            if ((j_ff + CNT_W'(1)) < cnt) begin
               j_in    = j_ff + CNT_W'(1);
               jptr_in = nxt(jptr_ff);
               rd_en   = 1'b1;
               rd_addr = nxt(jptr_ff);
            end else begin
               state_in = cqs_pkg::S_WB;
            end
         end
         cqs_pkg::S_WB: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = cur_ff;
            if ((i_ff + CNT_W'(2)) < cnt) begin
               i_in     = i_ff + CNT_W'(1);
               j_in     = i_ff + CNT_W'(2);
               ptr_in   = nxt(ptr_ff);
               jptr_in  = nxt(nxt(ptr_ff));
               rd_en    = 1'b1;
               rd_addr  = nxt(ptr_ff);
               state_in = cqs_pkg::S_LDI;
            end else begin
               status_in = cqs_pkg::ST_DONE;
               state_in  = cqs_pkg::S_EMIT;
            end
         end
         default: begin
            state_in = cqs_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hdl/circular_queue_with_sort.sv */
// Channel    Ports                           Beat
// request    req_valid req_stall req_data    one operation and its word
// response   rsp_valid rsp_stall rsp_data    one status, with a word on dequeue and display
//
// Enqueue and dequeue each return one response beat; display of n words returns n beats.
// Sort runs one compare a cycle through the single compare unit and the one-read, one-write
// storage port.
// A new operation is taken once the previous one has handed its last beat on.
// Reset clears head, tail and the sequencer; storage is not cleared.
// A stalled response holds in the output register while the next operation starts.
`include "circular_queue_with_sort_defines.svh"

module circular_queue_with_sort #(
   parameter int unsigned DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cqs_pkg::rsp_type rsp_data
);

   logic             res_valid;
   cqs_pkg::rsp_type res_data;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   cqs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   cqs_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .res_valid (res_valid),
      .res_data  (res_data),
      .out_free  (out_free)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CQS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `CQS_ASSERT_SAME(a_no_accept_while_emit, clock, reset, res_valid, req_stall)
   `CQS_ASSERT_SAME(a_word_before_last, clock, reset, rsp_valid && !rsp_data.last, rsp_data.element_valid)
   `CQS_ASSERT_SAME(a_fail_is_single, clock, reset, rsp_valid && (rsp_data.status != cqs_pkg::ST_DONE), rsp_data.last && !rsp_data.element_valid)

endmodule
